// ----- rtl/sadq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sadq_pkg
// shared types, constants and helpers of the sorted alarm deadline queue
// ----------------------------------------------------------------------------
package sadq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int TIME_W   = 64;
	localparam int ID_W     = 8;
	localparam int PERIOD_W = 32;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;
	localparam int REG_W    = 1;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd100000;

	// register index inside the config space
	localparam logic [REG_W-1:0] REG_FALLBACK_PERIOD = 1'b0;

	typedef enum logic [1:0] {
		OP_SLEEP  = 2'd0,
		OP_TICK   = 2'd1,
		OP_INIT   = 2'd2,
		OP_IGNORE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_QUEUED  = 3'd0,
		KIND_EXPIRED = 3'd1,
		KIND_FULL    = 3'd2,
		KIND_WOKEN   = 3'd3,
		KIND_COMPARE = 3'd4
	} kind_t;

	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [ID_W-1:0]   owner;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic  load_in;
		logic  calc;
		logic  idx_load;
		logic  rd;
		logic  rd_head;
		logic  shift_wr;
		logic  put_wr;
		logic  pop;
		logic  emit;
		kind_t emit_kind;
		logic  cmp_head;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic past;
		logic full;
		logic occ_zero;
		logic idx_zero;
		logic greater;
		logic due;
		logic out_free;
	} dp_sts_t;

	function automatic logic [TIME_W-1:0] min_time(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	// logical queue position to ram address in the ring
	function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
		input logic [CNT_W-1:0] lidx);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, lidx};
		if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/sadq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sadq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sadq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sadq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sadq_ctrl
// sequencer for sleep insertion, tick pops and compare updates
// ----------------------------------------------------------------------------
module sadq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire sadq_pkg::dp_sts_t sts,
	output sadq_pkg::dp_cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CALC,
		S_DISPATCH,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_TICK_RD,
		S_TICK_CMP
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		cmd.emit_kind = sadq_pkg::KIND_COMPARE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc  = 1'b1;
				state_nxt = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (sts.op)
					sadq_pkg::OP_SLEEP: begin
						if (sts.past) begin
							if (sts.out_free) begin
								cmd.emit      = 1'b1;
								cmd.emit_kind = sadq_pkg::KIND_EXPIRED;
								state_nxt     = S_IDLE;
							end
						end else if (sts.full) begin
							if (sts.out_free) begin
								cmd.emit      = 1'b1;
								cmd.emit_kind = sadq_pkg::KIND_FULL;
								state_nxt     = S_IDLE;
							end
						end else begin
							cmd.idx_load = 1'b1;
							state_nxt    = S_INS_RD;
						end
					end
					sadq_pkg::OP_TICK: begin
						state_nxt = S_TICK_RD;
					end
					sadq_pkg::OP_INIT: begin
						if (sts.out_free) begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = sadq_pkg::KIND_COMPARE;
							state_nxt     = S_IDLE;
						end
					end
					default: begin
						state_nxt = S_IDLE;
					end
				endcase
			end
			S_INS_RD: begin
				if (sts.idx_zero) begin
					state_nxt = S_INS_PUT;
				end else begin
					cmd.rd    = 1'b1;
					state_nxt = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				// later deadlines move one slot back, equal ones stay ahead
				if (sts.greater) begin
					cmd.shift_wr = 1'b1;
					state_nxt    = S_INS_RD;
				end else begin
					state_nxt = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				if (sts.out_free) begin
					cmd.put_wr    = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_kind = sadq_pkg::KIND_QUEUED;
					state_nxt     = S_IDLE;
				end
			end
			S_TICK_RD: begin
				if (sts.occ_zero) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = sadq_pkg::KIND_COMPARE;
						state_nxt     = S_IDLE;
					end
				end else begin
					cmd.rd      = 1'b1;
					cmd.rd_head = 1'b1;
					state_nxt   = S_TICK_CMP;
				end
			end
			S_TICK_CMP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.due) begin
						cmd.emit_kind = sadq_pkg::KIND_WOKEN;
						cmd.pop       = 1'b1;
						state_nxt     = S_TICK_RD;
					end else begin
						cmd.emit_kind = sadq_pkg::KIND_COMPARE;
						cmd.cmp_head  = 1'b1;
						state_nxt     = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/sadq_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sadq_dp
// input capture, wake time arithmetic, ring buffer and result register
// ----------------------------------------------------------------------------
module sadq_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sadq_pkg::dp_cmd_t              cmd,
	output sadq_pkg::dp_sts_t                   sts,
	input  wire logic [sadq_pkg::PERIOD_W-1:0]  period,
	input  wire logic [1:0]                     operation,
	input  wire logic [sadq_pkg::ID_W-1:0]      alarm_id,
	input  wire logic [sadq_pkg::TIME_W-1:0]    start_time,
	input  wire logic [sadq_pkg::TIME_W-1:0]    delay,
	input  wire logic [sadq_pkg::TIME_W-1:0]    now,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [2:0]                     kind,
	output logic      [sadq_pkg::ID_W-1:0]      alarm_id_res,
	output logic      [sadq_pkg::TIME_W-1:0]    wake_time,
	output logic                                compare_write,
	output logic      [sadq_pkg::TIME_W-1:0]    compare_value,
	output logic                                last
);

	logic [1:0]                    op_q;
	logic [sadq_pkg::ID_W-1:0]     id_q;
	logic [sadq_pkg::TIME_W-1:0]   start_q;
	logic [sadq_pkg::TIME_W-1:0]   delay_q;
	logic [sadq_pkg::TIME_W-1:0]   now_q;
	logic [sadq_pkg::TIME_W-1:0]   wake_q;
	logic [sadq_pkg::TIME_W-1:0]   horizon_q;
	logic [sadq_pkg::IDX_W-1:0]    head_q;
	logic [sadq_pkg::CNT_W-1:0]    occ_q;
	logic [sadq_pkg::CNT_W-1:0]    idx_q;

	logic [sadq_pkg::TIME_W:0]     sum_wide;
	logic [sadq_pkg::CNT_W-1:0]    idx_m1;
	logic [sadq_pkg::IDX_W-1:0]    slot_addr;
	logic [sadq_pkg::IDX_W-1:0]    raddr;
	logic [sadq_pkg::ENTRY_W-1:0]  wdata;
	logic [sadq_pkg::ENTRY_W-1:0]  rdata;
	sadq_pkg::entry_t              rd_entry;
	sadq_pkg::entry_t              new_entry;
	logic                          we;

	logic                          out_valid_q;
	logic [2:0]                    kind_q;
	logic [sadq_pkg::ID_W-1:0]     id_res_q;
	logic [sadq_pkg::TIME_W-1:0]   wake_res_q;
	logic                          cw_q;
	logic [sadq_pkg::TIME_W-1:0]   cv_q;
	logic                          last_q;

	logic [sadq_pkg::ID_W-1:0]     id_nxt;
	logic [sadq_pkg::TIME_W-1:0]   wake_nxt;
	logic                          cw_nxt;
	logic [sadq_pkg::TIME_W-1:0]   cv_nxt;
	logic                          last_nxt;

	// input capture, payload only
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= operation;
			id_q    <= alarm_id;
			start_q <= start_time;
			delay_q <= delay;
			now_q   <= now;
		end
		if (cmd.calc) begin
			wake_q    <= sum_wide[sadq_pkg::TIME_W] ? '1 : sum_wide[sadq_pkg::TIME_W-1:0];
			horizon_q <= now_q + {{(sadq_pkg::TIME_W - sadq_pkg::PERIOD_W){1'b0}}, period};
		end
	end

	assign sum_wide = {1'b0, start_q} + {1'b0, delay_q};

	// ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.idx_load) begin
				idx_q <= occ_q;
			end else if (cmd.shift_wr) begin
				idx_q <= idx_m1;
			end
			if (cmd.put_wr) begin
				occ_q <= occ_q + sadq_pkg::CNT_W'(1);
			end else if (cmd.pop) begin
				occ_q  <= occ_q - sadq_pkg::CNT_W'(1);
				head_q <= (head_q == sadq_pkg::IDX_W'(sadq_pkg::QUEUE_DEPTH - 1)) ?
					'0 : head_q + sadq_pkg::IDX_W'(1);
			end
		end
	end

	assign idx_m1    = idx_q - sadq_pkg::CNT_W'(1);
	assign slot_addr = sadq_pkg::phys_idx(head_q, idx_q);
	assign raddr     = cmd.rd_head ? head_q : sadq_pkg::phys_idx(head_q, idx_m1);

	assign new_entry.deadline = wake_q;
	assign new_entry.owner    = id_q;
	assign rd_entry           = sadq_pkg::entry_t'(rdata);
	assign we                 = cmd.shift_wr | cmd.put_wr;
	assign wdata              = cmd.put_wr ? new_entry : rdata;

	sadq_ram #(
		.WIDTH(sadq_pkg::ENTRY_W),
		.DEPTH(sadq_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (slot_addr),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	// status
	assign sts.op       = sadq_pkg::op_t'(op_q);
	assign sts.past     = wake_q < now_q;
	assign sts.full     = occ_q >= sadq_pkg::CNT_W'(sadq_pkg::QUEUE_DEPTH);
	assign sts.occ_zero = (occ_q == '0);
	assign sts.idx_zero = (idx_q == '0);
	assign sts.greater  = rd_entry.deadline > wake_q;
	assign sts.due      = rd_entry.deadline <= now_q;
	assign sts.out_free = !out_valid_q || out_ready;

	// result fields
	always_comb begin
		id_nxt   = id_q;
		wake_nxt = wake_q;
		cw_nxt   = 1'b0;
		cv_nxt   = '0;
		last_nxt = 1'b1;
		case (cmd.emit_kind) inside
			sadq_pkg::KIND_QUEUED: begin
				cw_nxt = (idx_q == '0);
				cv_nxt = (idx_q == '0) ? sadq_pkg::min_time(wake_q, horizon_q) : '0;
			end
			sadq_pkg::KIND_EXPIRED, sadq_pkg::KIND_FULL: begin
				cw_nxt = 1'b0;
			end
			sadq_pkg::KIND_WOKEN: begin
				id_nxt   = rd_entry.owner;
				wake_nxt = rd_entry.deadline;
				last_nxt = 1'b0;
			end
			sadq_pkg::KIND_COMPARE: begin
				id_nxt   = '0;
				wake_nxt = '0;
				cw_nxt   = 1'b1;
				cv_nxt   = cmd.cmp_head ?
					sadq_pkg::min_time(rd_entry.deadline, horizon_q) : horizon_q;
			end
			default: begin
				last_nxt = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q     <= cmd.emit_kind;
			id_res_q   <= id_nxt;
			wake_res_q <= wake_nxt;
			cw_q       <= cw_nxt;
			cv_q       <= cv_nxt;
			last_q     <= last_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign alarm_id_res  = id_res_q;
	assign wake_time     = wake_res_q;
	assign compare_write = cw_q;
	assign compare_value = cv_q;
	assign last          = last_q;

endmodule
`default_nettype wire

// ----- rtl/sorted_alarm_deadline_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_alarm_deadline_queue
// sequence from input accept to first result valid: the request is captured,
//   then wake time and horizon are computed; init and a rejected sleep
//   (expired or full) then load their result; a queued sleep first moves
//   each later entry back, reading from the tail, then loads its result
// tick: p woken beats, then the compare beat; output stalls delay every beat
// one item is handled at a time, set by the walk through the ram; the next
//   item is taken the cycle after its last beat is loaded
// reset: arst_n clears the queue count, ring head, sequencer and output
//   valid; entry storage is not cleared; fallback period returns to 100000
// ----------------------------------------------------------------------------
// The pending alarms sit in a ring buffer ram kept sorted earliest first.
// A sleep request walks from the tail toward the head, one slot per step
// (read, then compare and move back), and drops the new alarm into
// the hole. A tick pops from the head while the head is due. Results leave
// through a single output register so the next item can be taken while
// the last beat still waits.
// ----------------------------------------------------------------------------
module sorted_alarm_deadline_queue (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	// input channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     operation,
	input  wire logic [sadq_pkg::ID_W-1:0]      alarm_id,
	input  wire logic [sadq_pkg::TIME_W-1:0]    start_time,
	input  wire logic [sadq_pkg::TIME_W-1:0]    delay,
	input  wire logic [sadq_pkg::TIME_W-1:0]    now,

	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [2:0]                     kind,
	output logic      [sadq_pkg::ID_W-1:0]      alarm_id_res,
	output logic      [sadq_pkg::TIME_W-1:0]    wake_time,
	output logic                                compare_write,
	output logic      [sadq_pkg::TIME_W-1:0]    compare_value,
	output logic                                last,

	// config port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [sadq_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [sadq_pkg::DATA_W-1:0]    pwdata,
	output logic      [sadq_pkg::DATA_W-1:0]    prdata,
	output logic                                pready
);

	logic [sadq_pkg::PERIOD_W-1:0] period_q;
	logic [sadq_pkg::REG_W-1:0]    reg_sel;
	logic                          wr_en;
	sadq_pkg::dp_cmd_t             cmd;
	sadq_pkg::dp_sts_t             sts;

	// register file: word index taken above the byte offset
	assign reg_sel = paddr[sadq_pkg::ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= sadq_pkg::PERIOD_RESET;
		end else if (wr_en && (reg_sel == sadq_pkg::REG_FALLBACK_PERIOD)) begin
			period_q <= pwdata[sadq_pkg::PERIOD_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_sel)
			sadq_pkg::REG_FALLBACK_PERIOD: prdata = period_q;
			default:                       prdata = '0;
		endcase
	end

	// sequencer
	sadq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// queue storage, arithmetic and output register
	sadq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.period        (period_q),
		.operation     (operation),
		.alarm_id      (alarm_id),
		.start_time    (start_time),
		.delay         (delay),
		.now           (now),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.alarm_id_res  (alarm_id_res),
		.wake_time     (wake_time),
		.compare_write (compare_write),
		.compare_value (compare_value),
		.last          (last)
	);

endmodule
`default_nettype wire

// ----- rtl/sadq_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sadq_checker
// port level checks on the result channel of the deadline queue
// ----------------------------------------------------------------------------
module sadq_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [2:0]                  kind,
	input wire logic [sadq_pkg::ID_W-1:0]   alarm_id_res,
	input wire logic [sadq_pkg::TIME_W-1:0] wake_time,
	input wire logic                        compare_write,
	input wire logic [sadq_pkg::TIME_W-1:0] compare_value,
	input wire logic                        last
);

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) &&
		$stable(compare_value) && $stable(wake_time) && $stable(last))
		else $error("stalled result beat changed");

	// only a woken beat is followed by more beats of the same item
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind != sadq_pkg::KIND_WOKEN)))
		else $error("last flag does not match result kind");

	// no compare value without a compare write
	a_cv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !compare_write |-> compare_value == '0)
		else $error("compare value set without compare write");

	// a compare beat always writes and carries no alarm
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == sadq_pkg::KIND_COMPARE) |->
		compare_write && (alarm_id_res == '0) && (wake_time == '0))
		else $error("malformed compare update");

	// rejected and woken alarms never reprogram the timer
	a_no_cw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((kind == sadq_pkg::KIND_EXPIRED) || (kind == sadq_pkg::KIND_FULL) ||
		(kind == sadq_pkg::KIND_WOKEN)) |-> !compare_write)
		else $error("compare write on a non queued alarm result");

endmodule

bind sorted_alarm_deadline_queue sadq_checker u_sadq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.kind          (kind),
	.alarm_id_res  (alarm_id_res),
	.wake_time     (wake_time),
	.compare_write (compare_write),
	.compare_value (compare_value),
	.last          (last)
);
`default_nettype wire
